### rtl/wlrr_pkg.sv
// Shared types and constants of the wear-levelled record ring.
`default_nettype none
package wlrr_pkg;

  localparam int BYTE_W     = 8;
  localparam int ROW_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int RAW_W      = 10;

  localparam logic [BYTE_W-1:0] ERASED      = 8'hFF;
  localparam logic [BYTE_W-1:0] FMT_TX_BASE = 8'd250;
  localparam logic [BYTE_W-1:0] FMT_TX_LAST = 8'd249;
  localparam logic [ROW_W-1:0]  MIN_GEN     = 5'd3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENS = 2'd2;

  typedef enum logic [1:0] {
    REQ_MOUNT  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_RAW    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNCHANGED   = 3'd1,
    ST_NOT_MOUNTED = 3'd2,
    ST_NO_DATA     = 3'd3,
    ST_FORMATTED   = 3'd4,
    ST_LAYOUT      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_M_CHK, S_M_P0, S_M_PREV, S_M_RD, S_M_CMP, S_M_DONE,
    S_F_WR, S_R_RD, S_R_CAP, S_U_RD, S_U_CMP, S_U_NEXT, S_U_WR, S_EMIT
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_address;
    logic [BYTE_W-1:0] data_byte;
    req_type_t         req_type;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] newest_tx;
    logic [ROW_W-1:0]  newest_row;
    status_t           status;
    logic              last;
    logic [BYTE_W-1:0] out_byte;
  } res_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] base_address;
    logic [4:0]            record_bytes;
    logic [4:0]            generations;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/wlrr_store.sv
// Single-port byte store with registered read data.
`default_nettype none
module wlrr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire logic          we,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write at the port address; the read of the same address is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/wlrr_ctrl.sv
// Request sequencer: mount scan, format, read, update and raw write over one store port.
`default_nettype none
module wlrr_ctrl #(
  parameter int STORE_BYTES = 1024,
  parameter int RECORD_MAX  = 16,
  parameter int GEN_MAX     = 16,
  parameter int AW          = 10,
  parameter int EW          = 12
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wlrr_pkg::cfg_t cfg,
  input  wire logic           cfg_we,
  input  wire wlrr_pkg::req_t req,
  input  wire logic           req_valid,
  output logic                req_ready,
  output wlrr_pkg::res_t      res,
  output logic                res_valid,
  input  wire logic           res_free,
  output logic [AW-1:0]       mem_addr,
  output logic                mem_we,
  output logic [7:0]          mem_wdata,
  input  wire logic [7:0]     mem_rdata
);

  localparam int SW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

  wlrr_pkg::state_t  state, state_next;
  wlrr_pkg::status_t res_status;
  logic [AW-1:0] clr_addr;
  logic          mounted, real_seen, res_last;
  logic [4:0]    cur_row, tmp_row, r, i, sc;
  logic [7:0]    cur_tx, prev, res_byte;
  logic [EW-1:0] ptr, prev_ptr, cur_base, tmp_base;
  logic [7:0]    staging [RECORD_MAX];

  logic [5:0]    step;
  logic [EW-1:0] step_ext, base_ext, addr_sum, ptr_step, ring_end, raw_ext;
  logic [4:0]    off, gen, rb;
  logic [7:0]    stage_rd, prev_inc;
  logic          layout_bad, raw_ok, rd_last, wr_last, row_last, empty, seq_match, gap_match;

  assign gen      = cfg.generations;
  assign rb       = cfg.record_bytes;
  assign step     = {1'b0, rb} + 6'd1;
  assign step_ext = EW'(step);
  assign base_ext = EW'(cfg.base_address);
  assign raw_ext  = EW'(req.raw_address);
  assign raw_ok   = raw_ext < EW'(STORE_BYTES);
  assign ring_end = base_ext + EW'(gen) * step_ext;
  assign layout_bad = (rb < 5'd1) || (32'(rb) > RECORD_MAX) || (gen < wlrr_pkg::MIN_GEN) ||
                      (32'(gen) > GEN_MAX) || (ring_end > EW'(STORE_BYTES));

  // Shared address unit: row pointer plus byte offset
  assign off      = (state == wlrr_pkg::S_M_P0 || state == wlrr_pkg::S_M_RD) ? rb : i;
  assign addr_sum = ptr + EW'(off);
  assign ptr_step = ptr + step_ext;

  assign stage_rd  = staging[i[SW-1:0]];
  assign prev_inc  = prev + 8'd1;
  assign seq_match = mem_rdata == prev_inc;
  assign gap_match = (mem_rdata + {3'b000, gen}) == prev_inc;
  assign rd_last   = (i + 5'd1) == rb;
  assign wr_last   = i == rb;
  assign row_last  = (r + 5'd1) == gen;
  assign empty     = cur_row >= gen;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wlrr_pkg::S_CLEAR: if (clr_addr == CLR_LAST) state_next = wlrr_pkg::S_IDLE;
      wlrr_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req.req_type)
            wlrr_pkg::REQ_MOUNT: state_next = wlrr_pkg::S_M_CHK;
            wlrr_pkg::REQ_READ:
              state_next = (!mounted || empty) ? wlrr_pkg::S_EMIT : wlrr_pkg::S_R_RD;
            wlrr_pkg::REQ_UPDATE: begin
              if (!mounted) state_next = wlrr_pkg::S_EMIT;
              else if ((sc + 5'd1) < rb) state_next = wlrr_pkg::S_IDLE;
              else if (empty) state_next = wlrr_pkg::S_U_NEXT;
              else state_next = wlrr_pkg::S_U_RD;
            end
            default: state_next = wlrr_pkg::S_IDLE;
          endcase
        end
      end
      wlrr_pkg::S_M_CHK: state_next = layout_bad ? wlrr_pkg::S_EMIT : wlrr_pkg::S_M_P0;
      wlrr_pkg::S_M_P0:  state_next = wlrr_pkg::S_M_PREV;
      wlrr_pkg::S_M_PREV: state_next = wlrr_pkg::S_M_RD;
      wlrr_pkg::S_M_RD:  state_next = wlrr_pkg::S_M_CMP;
      wlrr_pkg::S_M_CMP: begin
        if (!seq_match && !gap_match) state_next = wlrr_pkg::S_F_WR;
        else if (row_last) state_next = wlrr_pkg::S_M_DONE;
        else state_next = wlrr_pkg::S_M_RD;
      end
      wlrr_pkg::S_M_DONE: state_next = wlrr_pkg::S_EMIT;
      wlrr_pkg::S_F_WR: if (wr_last && row_last) state_next = wlrr_pkg::S_EMIT;
      wlrr_pkg::S_R_RD:  state_next = wlrr_pkg::S_R_CAP;
      wlrr_pkg::S_R_CAP: state_next = wlrr_pkg::S_EMIT;
      wlrr_pkg::S_U_RD:  state_next = wlrr_pkg::S_U_CMP;
      wlrr_pkg::S_U_CMP: begin
        if (stage_rd != mem_rdata) state_next = wlrr_pkg::S_U_NEXT;
        else if (rd_last) state_next = wlrr_pkg::S_EMIT;
        else state_next = wlrr_pkg::S_U_RD;
      end
      wlrr_pkg::S_U_NEXT: state_next = wlrr_pkg::S_U_WR;
      wlrr_pkg::S_U_WR: if (wr_last) state_next = wlrr_pkg::S_EMIT;
      wlrr_pkg::S_EMIT: begin
        if (res_free) state_next = res_last ? wlrr_pkg::S_IDLE : wlrr_pkg::S_R_RD;
      end
      default: state_next = wlrr_pkg::S_IDLE;
    endcase
  end

  // Store port and handshake outputs
  always_comb begin
    req_ready = state == wlrr_pkg::S_IDLE;
    res_valid = state == wlrr_pkg::S_EMIT;
    mem_addr  = addr_sum[AW-1:0];
    mem_we    = 1'b0;
    mem_wdata = wlrr_pkg::ERASED;
    case (state)
      wlrr_pkg::S_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
      end
      wlrr_pkg::S_IDLE: begin
        mem_addr  = raw_ext[AW-1:0];
        mem_we    = req_valid && (req.req_type == wlrr_pkg::REQ_RAW) && raw_ok;
        mem_wdata = req.data_byte;
      end
      wlrr_pkg::S_F_WR: begin
        mem_we    = 1'b1;
        mem_wdata = wr_last ? ({3'b000, r} + wlrr_pkg::FMT_TX_BASE) : wlrr_pkg::ERASED;
      end
      wlrr_pkg::S_U_WR: begin
        mem_we    = 1'b1;
        mem_wdata = wr_last ? cur_tx : stage_rd;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign res.out_byte   = res_byte;
  assign res.last       = res_last;
  assign res.status     = res_status;
  assign res.newest_row = cur_row;
  assign res.newest_tx  = cur_tx;

  // Staging buffer for update bytes
  always_ff @(posedge clk) begin
    if (state == wlrr_pkg::S_IDLE && req_valid && req.req_type == wlrr_pkg::REQ_UPDATE &&
        mounted && 32'(sc) < RECORD_MAX) begin
      staging[sc[SW-1:0]] <= req.data_byte;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wlrr_pkg::S_CLEAR;
      clr_addr <= '0;
      mounted  <= 1'b0;
      cur_row  <= '0;
      cur_tx   <= '0;
      sc       <= '0;
    end else begin
      state <= state_next;
      case (state)
        wlrr_pkg::S_CLEAR: clr_addr <= clr_addr + AW'(1);
        wlrr_pkg::S_IDLE: begin
          if (req_valid) begin
            res_byte   <= '0;
            res_last   <= 1'b1;
            res_status <= wlrr_pkg::ST_NOT_MOUNTED;
            i          <= '0;
            real_seen  <= 1'b0;
            ptr        <= cur_base;
            case (req.req_type)
              wlrr_pkg::REQ_MOUNT: begin
                mounted <= 1'b0;
                sc      <= '0;
              end
              wlrr_pkg::REQ_READ: if (mounted) res_status <= wlrr_pkg::ST_NO_DATA;
              wlrr_pkg::REQ_UPDATE: begin
                if (mounted) sc <= ((sc + 5'd1) < rb) ? sc + 5'd1 : 5'd0;
              end
              default: ;
            endcase
          end
        end
        wlrr_pkg::S_M_CHK: begin
          ptr        <= base_ext;
          res_status <= wlrr_pkg::ST_LAYOUT;
        end
        wlrr_pkg::S_M_PREV: begin
          prev     <= mem_rdata;
          r        <= 5'd1;
          prev_ptr <= ptr;
          ptr      <= ptr_step;
          tmp_row  <= gen - 5'd1;
        end
        wlrr_pkg::S_M_CMP: begin
          if (seq_match || gap_match) begin
            if (!seq_match) begin
              cur_tx   <= prev;
              tmp_row  <= r - 5'd1;
              tmp_base <= prev_ptr;
            end
            prev     <= mem_rdata;
            r        <= r + 5'd1;
            prev_ptr <= ptr;
            ptr      <= ptr_step;
          end else begin
            ptr <= base_ext;
            r   <= '0;
            i   <= '0;
          end
        end
        wlrr_pkg::S_M_DONE: begin
          cur_row    <= tmp_row;
          mounted    <= 1'b1;
          res_status <= wlrr_pkg::ST_OK;
          if (tmp_row == gen - 5'd1) begin
            cur_base <= prev_ptr;
            cur_tx   <= prev;
          end else begin
            cur_base <= tmp_base;
          end
        end
        wlrr_pkg::S_F_WR: begin
          if (wr_last) begin
            i   <= '0;
            r   <= r + 5'd1;
            ptr <= ptr_step;
            if (row_last) begin
              cur_row    <= gen;
              cur_tx     <= {3'b000, gen} + wlrr_pkg::FMT_TX_LAST;
              mounted    <= 1'b1;
              res_status <= wlrr_pkg::ST_FORMATTED;
            end
          end else begin
            i <= i + 5'd1;
          end
        end
        wlrr_pkg::S_R_CAP: begin
          res_byte   <= mem_rdata;
          res_last   <= rd_last;
          real_seen  <= real_seen || (mem_rdata != wlrr_pkg::ERASED);
          res_status <= (rd_last && !real_seen && mem_rdata == wlrr_pkg::ERASED) ?
                        wlrr_pkg::ST_NO_DATA : wlrr_pkg::ST_OK;
        end
        wlrr_pkg::S_U_CMP: begin
          res_status <= wlrr_pkg::ST_UNCHANGED;
          if (stage_rd == mem_rdata && !rd_last) i <= i + 5'd1;
        end
        wlrr_pkg::S_U_NEXT: begin
          cur_tx <= cur_tx + 8'd1;
          i      <= '0;
          if (empty || (cur_row + 5'd1) >= gen) begin
            cur_row  <= '0;
            cur_base <= base_ext;
            ptr      <= base_ext;
          end else begin
            cur_row  <= cur_row + 5'd1;
            cur_base <= cur_base + step_ext;
            ptr      <= cur_base + step_ext;
          end
        end
        wlrr_pkg::S_U_WR: begin
          res_status <= wlrr_pkg::ST_OK;
          if (!wr_last) i <= i + 5'd1;
        end
        wlrr_pkg::S_EMIT: if (res_free && !res_last) i <= i + 5'd1;
        default: ;
      endcase
      // Any register write drops the mount and the staged bytes
      if (cfg_we) begin
        mounted <= 1'b0;
        sc      <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/wear_levelled_record_ring_core.sv
// Wear-levelled record ring: a single-record ring of generation rows in a byte store.
// Raw writes and staged update bytes are handled on acceptance; a mount scans the rows and may
// format the ring; a read returns the record byte by byte; an update with a full record compares
// it with the newest row and writes a new row if it differs. All requests share the one store port.
// One request at a time; results leave through a register.
// Reset: synchronous; afterwards the store is filled with 0xFF before requests are taken.
`default_nettype none
module wear_levelled_record_ring_core #(
  parameter int STORE_BYTES = 1024,
  parameter int RECORD_MAX  = 16,
  parameter int GEN_MAX     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // req_type[1:0], data_byte[9:2], raw_address[19:10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_byte[7:0], newest_row[12:8], newest_tx[20:13]
  output logic             m_tlast,
  output logic [2:0]       m_tuser,   // status[2:0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int EW = (AW + 1 > 13) ? AW + 1 : 13;

  wlrr_pkg::cfg_t cfg;
  wlrr_pkg::req_t req;
  wlrr_pkg::res_t res;
  logic          res_valid, out_free, cfg_hit;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata, mem_rdata;

  assign req      = wlrr_pkg::req_t'(s_tdata[19:0]);
  assign out_free = !m_tvalid || m_tready;
  assign cfg_hit  = cfg_we && (cfg_index == wlrr_pkg::CFG_BASE ||
                               cfg_index == wlrr_pkg::CFG_RECB ||
                               cfg_index == wlrr_pkg::CFG_GENS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.record_bytes <= 5'd1;
      cfg.generations  <= 5'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        wlrr_pkg::CFG_BASE: cfg.base_address <= cfg_data;
        wlrr_pkg::CFG_RECB: cfg.record_bytes <= cfg_data[4:0];
        wlrr_pkg::CFG_GENS: cfg.generations  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Output register: load a result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_tdata <= {3'b000, res.newest_tx, res.newest_row, res.out_byte};
      m_tlast <= res.last;
      m_tuser <= res.status;
    end
  end

  wlrr_ctrl #(
    .STORE_BYTES(STORE_BYTES), .RECORD_MAX(RECORD_MAX), .GEN_MAX(GEN_MAX),
    .AW(AW), .EW(EW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .cfg_we(cfg_hit),
    .req(req), .req_valid(s_tvalid), .req_ready(s_tready),
    .res(res), .res_valid(res_valid), .res_free(out_free),
    .mem_addr(mem_addr), .mem_we(mem_we), .mem_wdata(mem_wdata), .mem_rdata(mem_rdata)
  );

  wlrr_store #(.DEPTH(STORE_BYTES), .AW(AW)) u_store (
    .clk(clk), .addr(mem_addr), .we(mem_we), .wdata(mem_wdata), .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

### rtl/wlrr_checker.sv
// Port-level checks of the record ring core, bound to the top level.
`default_nettype none
module wlrr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [23:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic        m_tlast,
  input wire logic [2:0]  m_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  // Block requests during the store clear after reset
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during store clear");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // Raw writes produce no result
  a_raw: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] == wlrr_pkg::REQ_RAW && !m_tvalid |=> !m_tvalid)
    else $error("raw write produced a result");

  // Non-final read bytes carry an ok status
  a_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == wlrr_pkg::ST_OK)
    else $error("status on non-final result");

endmodule

bind wear_levelled_record_ring_core wlrr_checker u_wlrr_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tuser(m_tuser)
);
`default_nettype wire

### bench/wear_levelled_record_ring_core_tb.sv
// Self-checking bench for the wear-levelled record ring core: directed and random traffic against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module wear_levelled_record_ring_core_tb;

  localparam int STORE_SIZE = 1024;
  localparam int REC_LIMIT  = 16;
  localparam int GEN_LIMIT  = 16;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE     = 80;

  // Predicts the ring and holds the results still owed by the block
  class ring_scoreboard;
    logic [7:0]      mem [STORE_SIZE];
    int unsigned     base_addr, rec_len, gen_cnt;
    bit              mounted;
    int unsigned     cur_row;
    logic [7:0]      cur_tx;
    logic [7:0]      staged_bytes [REC_LIMIT];
    int unsigned     staged_cnt;
    wlrr_pkg::res_t  owed_q [$];
    int              errors;

    function new();
      foreach (mem[i]) mem[i] = wlrr_pkg::ERASED;
      foreach (staged_bytes[i]) staged_bytes[i] = 8'h00;
      base_addr = 0; rec_len = 1; gen_cnt = 3;
      mounted = 0; cur_row = 0; cur_tx = 8'h00; staged_cnt = 0; errors = 0;
    endfunction

    function logic [7:0] peek(int unsigned a);
      return (a < STORE_SIZE) ? mem[a] : wlrr_pkg::ERASED;
    endfunction

    function void poke(int unsigned a, logic [7:0] v);
      if (a < STORE_SIZE) mem[a] = v;
    endfunction

    function int unsigned row_base(int unsigned r);
      return base_addr + r * (rec_len + 1);
    endfunction

    function void owe(logic [7:0] b, logic lst, wlrr_pkg::status_t st);
      wlrr_pkg::res_t r;
      r.out_byte = b; r.last = lst; r.status = st;
      r.newest_row = cur_row[4:0]; r.newest_tx = cur_tx;
      owed_q.push_back(r);
    endfunction

    function void configure(logic [1:0] idx, logic [9:0] val);
      if (idx == wlrr_pkg::CFG_BASE) base_addr = val;
      else if (idx == wlrr_pkg::CFG_RECB) rec_len = val[4:0];
      else if (idx == wlrr_pkg::CFG_GENS) gen_cnt = val[4:0];
      else return;
      mounted = 0; staged_cnt = 0;
    endfunction

    function void format_ring();
      for (int unsigned r = 0; r < gen_cnt; r++) begin
        for (int unsigned i = 0; i < rec_len; i++) poke(row_base(r) + i, wlrr_pkg::ERASED);
        poke(row_base(r) + rec_len, 8'(r + wlrr_pkg::FMT_TX_BASE));
      end
      cur_row = gen_cnt;
      cur_tx = 8'(wlrr_pkg::FMT_TX_LAST + gen_cnt);
    endfunction

    function void mount();
      logic [7:0] prev, chk;
      int unsigned row;
      bit formatted;
      mounted = 0; staged_cnt = 0; formatted = 0;
      if (rec_len < 1 || rec_len > REC_LIMIT || gen_cnt < wlrr_pkg::MIN_GEN ||
          gen_cnt > GEN_LIMIT || base_addr + gen_cnt * (rec_len + 1) > STORE_SIZE) begin
        owe(8'h00, 1'b1, wlrr_pkg::ST_LAYOUT);
        return;
      end
      prev = peek(row_base(0) + rec_len);
      row = gen_cnt - 1;
      // Walk the transaction bytes looking for wrap gaps; the last gap found sets the newest row
      for (int unsigned r = 1; r < gen_cnt; r++) begin
        chk = peek(row_base(r) + rec_len);
        if (chk == 8'(prev + 1)) begin
          prev = chk;
        end else if (8'(chk + gen_cnt) == 8'(prev + 1)) begin
          cur_tx = prev; row = r - 1; prev = chk;
        end else begin
          format_ring(); formatted = 1;
          break;
        end
      end
      if (!formatted) begin
        cur_row = row;
        if (row == gen_cnt - 1) cur_tx = peek(row_base(row) + rec_len);
      end
      mounted = 1;
      owe(8'h00, 1'b1, formatted ? wlrr_pkg::ST_FORMATTED : wlrr_pkg::ST_OK);
    endfunction

    function void read_record();
      logic [7:0] b;
      bit real_data;
      real_data = 0;
      if (!mounted) begin owe(8'h00, 1'b1, wlrr_pkg::ST_NOT_MOUNTED); return; end
      if (cur_row >= gen_cnt) begin owe(8'h00, 1'b1, wlrr_pkg::ST_NO_DATA); return; end
      for (int unsigned i = 0; i < rec_len; i++) begin
        b = peek(row_base(cur_row) + i);
        if (b != wlrr_pkg::ERASED) real_data = 1;
        if (i + 1 == rec_len)
          owe(b, 1'b1, real_data ? wlrr_pkg::ST_OK : wlrr_pkg::ST_NO_DATA);
        else owe(b, 1'b0, wlrr_pkg::ST_OK);
      end
    endfunction

    function void update_byte(logic [7:0] v);
      bit changed;
      changed = 0;
      if (!mounted) begin owe(8'h00, 1'b1, wlrr_pkg::ST_NOT_MOUNTED); return; end
      if (staged_cnt < REC_LIMIT) staged_bytes[staged_cnt] = v;
      staged_cnt++;
      if (staged_cnt < rec_len) return;
      staged_cnt = 0;
      // Compare the staged record with the newest row
      if (cur_row >= gen_cnt) changed = 1;
      else
        for (int unsigned i = 0; i < rec_len; i++)
          if (staged_bytes[i] != peek(row_base(cur_row) + i)) changed = 1;
      if (!changed) begin owe(8'h00, 1'b1, wlrr_pkg::ST_UNCHANGED); return; end
      cur_tx = cur_tx + 8'd1;
      cur_row = (cur_row + 1 >= gen_cnt) ? 0 : cur_row + 1;
      for (int unsigned i = 0; i < rec_len; i++) poke(row_base(cur_row) + i, staged_bytes[i]);
      poke(row_base(cur_row) + rec_len, cur_tx);
      owe(8'h00, 1'b1, wlrr_pkg::ST_OK);
    endfunction

    function void note_request(wlrr_pkg::req_type_t kind, logic [7:0] d, logic [9:0] a);
      case (kind)
        wlrr_pkg::REQ_MOUNT:  mount();
        wlrr_pkg::REQ_READ:   read_record();
        wlrr_pkg::REQ_UPDATE: update_byte(d);
        default:              poke(a, d);
      endcase
    endfunction

    function void check_result(wlrr_pkg::res_t got);
      wlrr_pkg::res_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result: byte %h last %b status %0d row %0d tx %h", $realtime,
                 got.out_byte, got.last, got.status, got.newest_row, got.newest_tx);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected byte %h last %b status %0d row %0d tx %h", $realtime,
                 e.out_byte, e.last, e.status, e.newest_row, e.newest_tx);
        $display("%0t:          actual   byte %h last %b status %0d row %0d tx %h", $realtime,
                 got.out_byte, got.last, got.status, got.newest_row, got.newest_tx);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  ring_scoreboard sb;
  int          idle_cycles;
  int          burst_left;
  int          ready_mode, mode_left;
  logic [7:0]  last_record [REC_LIMIT];
  int unsigned cur_base, cur_len, cur_gens;

  wear_levelled_record_ring_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Take results and vary the receiver's stall pattern
  always @(posedge clk) begin
    wlrr_pkg::res_t got;
    if (rst) begin
      m_tready <= 1'b0;
      ready_mode <= 0;
      mode_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.out_byte = m_tdata[7:0];
        got.newest_row = m_tdata[12:8];
        got.newest_tx = m_tdata[20:13];
        got.last = m_tlast;
        got.status = wlrr_pkg::status_t'(m_tuser);
        sb.check_result(got);
      end
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (mode_left % 7) > 4;
      endcase
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("wear_levelled_record_ring_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, with bursts and gaps on the sending side
  task automatic send(wlrr_pkg::req_type_t kind, logic [7:0] d, logic [9:0] a);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, a, d, kind};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, d, a);
  endtask

  // Hold off until every owed result has arrived, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write, with the write enable dropped again before the task returns
  task automatic write_cfg(logic [1:0] idx, logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.configure(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(int unsigned b, int unsigned n, int unsigned g);
    drain();
    write_cfg(wlrr_pkg::CFG_BASE, 10'(b));
    write_cfg(wlrr_pkg::CFG_RECB, 10'(n));
    write_cfg(wlrr_pkg::CFG_GENS, 10'(g));
    cur_base = b; cur_len = n; cur_gens = g;
  endtask

  // Send one full record, either fresh or a repeat of the last one
  task automatic send_record(bit repeat_last);
    for (int unsigned i = 0; i < cur_len && i < REC_LIMIT; i++) begin
      if (!repeat_last) last_record[i] = 8'($urandom_range(0, 255));
      send(wlrr_pkg::REQ_UPDATE, last_record[i], 10'($urandom_range(0, 1023)));
    end
  endtask

  // Mixed traffic on the current layout
  task automatic random_phase(int count);
    int pick;
    int unsigned span;
    span = cur_gens * (cur_len + 1);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send(wlrr_pkg::REQ_MOUNT, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
      else if (pick < 32)
        send(wlrr_pkg::REQ_READ, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
      else if (pick < 58) send_record(1'b0);
      else if (pick < 72) send_record(1'b1);
      else if (pick < 80)
        send(wlrr_pkg::REQ_UPDATE, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
      else if (pick < 90 && cur_base + span <= STORE_SIZE)
        send(wlrr_pkg::REQ_RAW, 8'($urandom_range(0, 255)),
             10'(cur_base + $urandom_range(0, span - 1)));
      else if (pick < 95)
        send(wlrr_pkg::REQ_RAW, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
      else drain();
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= wlrr_pkg::CFG_BASE;
    cfg_data <= '0;
    burst_left = 0;
    cur_base = 0; cur_len = 1; cur_gens = 3;
    foreach (last_record[i]) last_record[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: unmounted requests, format of a blank ring, write, repeat, corrupt
    send(wlrr_pkg::REQ_READ, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_UPDATE, 8'hFF, 10'h3FF);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_READ, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_UPDATE, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_READ, 8'hFF, 10'h3FF);
    send(wlrr_pkg::REQ_UPDATE, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_UPDATE, 8'hFF, 10'h000);
    send(wlrr_pkg::REQ_READ, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_READ, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_RAW, 8'hFF, 10'h3FF);
    send(wlrr_pkg::REQ_RAW, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_RAW, 8'h5A, 10'h003);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_UPDATE, 8'hA5, 10'h2AA);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h155);
    drain();

    // Largest ring at both ends of the store, then bad layouts
    set_layout(0, 16, 16);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    random_phase(5);
    set_layout(752, 16, 16);
    random_phase(5);
    set_layout(1023, 1, 3);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_READ, 8'h00, 10'h000);
    send(wlrr_pkg::REQ_UPDATE, 8'h12, 10'h000);
    set_layout(300, 0, 5);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    set_layout(10, 20, 4);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    set_layout(10, 3, 2);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    set_layout(10, 3, 31);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);

    // Small rings, where wraps and gaps come often
    set_layout(5, 4, 5);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    random_phase(15);
    set_layout(1011, 1, 3);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    random_phase(15);
    set_layout(100, 2, 4);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    random_phase(15);
    set_layout(511, 7, 9);
    send(wlrr_pkg::REQ_MOUNT, 8'h00, 10'h000);
    random_phase(6);
    drain();

    if (sb.errors == 0 && sb.owed_q.size() == 0)
      $display("wear_levelled_record_ring_core_tb passed");
    else
      $display("wear_levelled_record_ring_core_tb failed");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/wlrr_pkg.sv
rtl/wlrr_store.sv
rtl/wlrr_ctrl.sv
rtl/wear_levelled_record_ring_core.sv
rtl/wlrr_checker.sv
bench/wear_levelled_record_ring_core_tb.sv
